// ===== src/mcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsp_pkg
// Types and constants shared by the servo slew positioner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsp_pkg;

	localparam int unsigned POS_W    = 16;
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned REQ_W    = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned S_DATA_W = 8;
	localparam int unsigned M_DATA_W = 32;

	localparam logic [POS_W-1:0] RANGE_LO_RST  = 16'd1000;
	localparam logic [POS_W-1:0] RANGE_HI_RST  = 16'd2000;
	localparam logic [POS_W-1:0] STEP_SIZE_RST = 16'd10;
	localparam logic [POS_W-1:0] POS_RST       = 16'd1500;

	typedef enum logic [REQ_W-1:0] {
		REQ_SET_LEFT  = 2'd0,
		REQ_SET_RIGHT = 2'd1,
		REQ_TICK      = 2'd2
	} req_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_LO    = 3'd0,
		CFG_RANGE_HI    = 3'd1,
		CFG_STEP_SIZE   = 3'd2,
		CFG_END_SENSE   = 3'd3,
		CFG_CMD_SENSE   = 3'd4
	} cfg_idx_e_t;

	typedef struct packed {
		logic [POS_W-1:0] range_lo;
		logic [POS_W-1:0] range_hi;
		logic [POS_W-1:0] step_size;
		logic             end_sense_enable;
		logic             command_sense_enable;
	} cfg_t;

	// per-channel state as seen by the tick logic
	typedef struct packed {
		logic             cmd_left;
		logic             cmd_right;
		logic             flag_left;
		logic             flag_right;
		logic [POS_W-1:0] position;
	} chan_state_t;

	typedef struct packed {
		logic             end_left;
		logic             end_right;
		logic             btn_left;
		logic             btn_right;
	} switches_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             at_left;
		logic             at_right;
		logic             left_changed;
		logic             right_changed;
		logic             left_request;
		logic             right_request;
	} tick_res_t;

endpackage

`default_nettype wire

// ===== src/mcsp_tick.sv =====
// ----------------------------------------------------------------------------
// mcsp_tick
// Single-pass slew step: new position, end flags and button requests of one
// channel from its current state, the switch samples and the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsp_tick
	import mcsp_pkg::*;
(
	input  var cfg_t        cfg,
	input  var chan_state_t st,
	input  var switches_t   sw,
	output tick_res_t       res
);

	localparam int unsigned EXT_W = POS_W + 2;

	logic signed [EXT_W-1:0] pos_x;
	logic signed [EXT_W-1:0] step_x;
	logic signed [EXT_W-1:0] lo_x;
	logic signed [EXT_W-1:0] hi_x;
	logic signed [EXT_W-1:0] mid_x;
	logic [POS_W:0]          sum_lh;
	logic                    end_l;
	logic                    end_r;
	logic [POS_W-1:0]        pos_n;
	logic                    fl_n;
	logic                    fr_n;

	assign pos_x  = signed'({2'b00, st.position});
	assign step_x = signed'({2'b00, cfg.step_size});
	assign lo_x   = signed'({2'b00, cfg.range_lo});
	assign hi_x   = signed'({2'b00, cfg.range_hi});
	assign sum_lh = {1'b0, cfg.range_lo} + {1'b0, cfg.range_hi};
	assign mid_x  = signed'({2'b00, sum_lh[POS_W:1]});

	assign end_l = sw.end_left & cfg.end_sense_enable;
	assign end_r = sw.end_right & cfg.end_sense_enable;

	// all moves below stay inside 0..65535, so the low bits are exact
	always_comb begin
		pos_n = st.position;
		fl_n  = st.flag_left;
		fr_n  = st.flag_right;
		if (st.cmd_left == st.cmd_right) begin
			fl_n = 1'b0;
			fr_n = 1'b0;
			if (pos_x > mid_x + step_x) begin
				pos_n = st.position - cfg.step_size;
			end else if (pos_x < mid_x - step_x) begin
				pos_n = st.position + cfg.step_size;
			end
		end else if (st.cmd_left) begin
			fr_n = 1'b0;
			if (end_l) begin
				fl_n = 1'b1;
			end else if (pos_x > hi_x - step_x) begin
				pos_n = cfg.range_hi;
				fl_n  = 1'b1;
			end else begin
				pos_n = st.position + cfg.step_size;
				fl_n  = 1'b0;
			end
		end else begin
			fl_n = 1'b0;
			if (end_r) begin
				fr_n = 1'b1;
			end else if (pos_x < lo_x + step_x) begin
				pos_n = cfg.range_lo;
				fr_n  = 1'b1;
			end else begin
				pos_n = st.position - cfg.step_size;
				fr_n  = 1'b0;
			end
		end
	end

	assign res.position      = pos_n;
	assign res.at_left       = fl_n;
	assign res.at_right      = fr_n;
	assign res.left_changed  = fl_n ^ st.flag_left;
	assign res.right_changed = fr_n ^ st.flag_right;
	assign res.left_request  = cfg.command_sense_enable & ~st.cmd_left & sw.btn_left;
	assign res.right_request = cfg.command_sense_enable & ~st.cmd_right & sw.btn_right;

endmodule

`default_nettype wire

// ===== src/multi_channel_servo_slew_positioner_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_servo_slew_positioner_core
// Multi-channel servo positioner: command writes and slew ticks per channel.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle unless a tick waits for room in the result
// register; set by the single input register feeding the tick logic and the
// result register, which drives m_tvalid; channel state lives in flip-flops
// reset: all channel state clears, positions go to 1500, registers to reset values
`default_nettype none

module multi_channel_servo_slew_positioner_core
	import mcsp_pkg::*;
#(
	parameter int unsigned CHANNELS = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// configuration write port
	input  wire                   cfg_we,
	input  wire [CFG_IDX_W-1:0]   cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_data,
	// request stream
	input  wire                   s_tvalid,
	output logic                  s_tready,
	// channel[2:0], command_value[3], end_left_switch[4], end_right_switch[5],
	// cmd_left_switch[6], cmd_right_switch[7]
	input  wire [S_DATA_W-1:0]    s_tdata,
	// req_type[1:0]
	input  wire [REQ_W-1:0]       s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// out_channel[2:0], position[18:3], at_left[19], at_right[20],
	// left_flag_changed[21], right_flag_changed[22], left_request[23],
	// right_request[24], zero above
	output logic [M_DATA_W-1:0]   m_tdata
);

	localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// configuration registers
	cfg_t cfg_q;

	// channel state
	logic [CHANNELS-1:0] cmd_l_q;
	logic [CHANNELS-1:0] cmd_r_q;
	logic [CHANNELS-1:0] flag_l_q;
	logic [CHANNELS-1:0] flag_r_q;
	logic [POS_W-1:0]    pos_q [CHANNELS];

	// input stage
	logic                valid_s1;
	req_e_t              req_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic                val_s1;
	switches_t           sw_s1;

	// result register
	logic                out_valid_q;
	logic [CHAN_W-1:0]   out_chan_q;
	tick_res_t           out_res_q;

	logic                in_range;
	logic [CH_W-1:0]     idx;
	logic                is_tick;
	logic                is_set_l;
	logic                is_set_r;
	logic                out_free;
	logic                go_s1;
	chan_state_t         st;
	tick_res_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_lo             <= RANGE_LO_RST;
			cfg_q.range_hi             <= RANGE_HI_RST;
			cfg_q.step_size            <= STEP_SIZE_RST;
			cfg_q.end_sense_enable     <= 1'b1;
			cfg_q.command_sense_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RANGE_LO:  cfg_q.range_lo             <= cfg_data;
				CFG_RANGE_HI:  cfg_q.range_hi             <= cfg_data;
				CFG_STEP_SIZE: cfg_q.step_size            <= cfg_data;
				CFG_END_SENSE: cfg_q.end_sense_enable     <= cfg_data[0];
				CFG_CMD_SENSE: cfg_q.command_sense_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_range = ({1'b0, chan_s1} < (CHAN_W+1)'(CHANNELS));
	assign idx      = CH_W'(chan_s1);
	assign is_tick  = valid_s1 && in_range && (req_s1 == REQ_TICK);
	assign is_set_l = valid_s1 && in_range && (req_s1 == REQ_SET_LEFT);
	assign is_set_r = valid_s1 && in_range && (req_s1 == REQ_SET_RIGHT);

	assign out_free = !out_valid_q || m_tready;
	// only a tick needs room in the result register
	assign go_s1    = valid_s1 && (!is_tick || out_free);
	assign s_tready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1       <= req_e_t'(s_tuser);
			chan_s1      <= s_tdata[2:0];
			val_s1       <= s_tdata[3];
			sw_s1.end_left  <= s_tdata[4];
			sw_s1.end_right <= s_tdata[5];
			sw_s1.btn_left  <= s_tdata[6];
			sw_s1.btn_right <= s_tdata[7];
		end
	end

	assign st.cmd_left   = cmd_l_q[idx];
	assign st.cmd_right  = cmd_r_q[idx];
	assign st.flag_left  = flag_l_q[idx];
	assign st.flag_right = flag_r_q[idx];
	assign st.position   = pos_q[idx];

	mcsp_tick u_tick (
		.cfg (cfg_q),
		.st  (st),
		.sw  (sw_s1),
		.res (res)
	);

	// state is written as the item leaves the input stage, so the next item
	// on the same channel already sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_l_q  <= '0;
			cmd_r_q  <= '0;
			flag_l_q <= '0;
			flag_r_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i] <= POS_RST;
			end
		end else if (go_s1) begin
			if (is_set_l) begin
				cmd_l_q[idx] <= val_s1;
			end
			if (is_set_r) begin
				cmd_r_q[idx] <= val_s1;
			end
			if (is_tick) begin
				flag_l_q[idx] <= res.at_left;
				flag_r_q[idx] <= res.at_right;
				pos_q[idx]    <= res.position;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && is_tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_tick) begin
			out_chan_q <= chan_s1;
			out_res_q  <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0,
		out_res_q.right_request, out_res_q.left_request,
		out_res_q.right_changed, out_res_q.left_changed,
		out_res_q.at_right, out_res_q.at_left,
		out_res_q.position, out_chan_q};

	// a channel is never at both ends at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(flag_l_q & flag_r_q) == '0)
		else $error("channel flagged at both ends");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_res_q.at_left && out_res_q.at_right))
		else $error("result flags both ends");

	// a new result only comes from a tick leaving the input stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go_s1 && is_tick))
		else $error("result without tick");

	// a held tick keeps its stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !go_s1) |=> (valid_s1 && $stable(chan_s1) && $stable(req_s1)))
		else $error("stalled item lost");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams command and tick transactions into the servo slew positioner core,
// predicts each tick's result from a per-channel model of positions, commands
// and end flags, and checks every result field as it leaves the block.
// ----------------------------------------------------------------------------

module tb_top;
	import mcsp_pkg::*;

	localparam int N_CHAN    = 8;
	localparam int LONG_HOLD = 300;
	localparam int LIMIT     = 1000000;
	localparam logic [REQ_W-1:0]     REQ_UNUSED     = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [CHAN_W-1:0] chan;
		logic              value;
		logic              end_left;
		logic              end_right;
		logic              btn_left;
		logic              btn_right;
	} servo_req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		tick_res_t         res;
	} servo_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic [REQ_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;

	// predictor state
	cfg_t             servo_cfg;
	logic             cmd_left  [N_CHAN];
	logic             cmd_right [N_CHAN];
	logic             flag_left [N_CHAN];
	logic             flag_right[N_CHAN];
	logic [POS_W-1:0] chan_pos  [N_CHAN];

	servo_req_t    pending_reqs[$];
	servo_result_t expected_ticks[$];
	servo_req_t    tx_item;
	int            queued_cnt = 0;
	int            accepted_cnt = 0;
	int            mismatches = 0;
	int            tx_gap = 0;
	int            rx_hold = 0;
	int            cycles = 0;
	logic          quiet_tx = 1'b0;
	logic          quiet_rx = 1'b0;
	logic          long_hold = 1'b0;

	multi_channel_servo_slew_positioner_core #(
		.CHANNELS(N_CHAN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic logic chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// applies one accepted request to the channel model, queues a tick's result
	function automatic void apply_request(input servo_req_t r);
		int            pos;
		int            stride;
		int            lo;
		int            hi;
		int            mid;
		logic          end_l;
		logic          end_r;
		logic          old_l;
		logic          old_r;
		logic          new_l;
		logic          new_r;
		servo_result_t want;
		if (r.chan >= N_CHAN) return;
		case (r.req)
			REQ_SET_LEFT: begin
				cmd_left[r.chan] = r.value;
			end
			REQ_SET_RIGHT: begin
				cmd_right[r.chan] = r.value;
			end
			REQ_TICK: begin
				end_l  = r.end_left & servo_cfg.end_sense_enable;
				end_r  = r.end_right & servo_cfg.end_sense_enable;
				pos    = int'(chan_pos[r.chan]);
				stride = int'(servo_cfg.step_size);
				lo     = int'(servo_cfg.range_lo);
				hi     = int'(servo_cfg.range_hi);
				mid    = (lo + hi) / 2;
				old_l  = flag_left[r.chan];
				old_r  = flag_right[r.chan];
				new_l  = old_l;
				new_r  = old_r;
				if (cmd_left[r.chan] == cmd_right[r.chan]) begin
					// slew back toward the midpoint
					new_l = 1'b0;
					new_r = 1'b0;
					if (pos > mid + stride) pos -= stride;
					else if (pos < mid - stride) pos += stride;
				end else if (cmd_left[r.chan]) begin
					new_r = 1'b0;
					if (end_l) begin
						new_l = 1'b1;
					end else if (pos > hi - stride) begin
						pos = hi;
						new_l = 1'b1;
					end else begin
						pos += stride;
						new_l = 1'b0;
					end
				end else begin
					new_l = 1'b0;
					if (end_r) begin
						new_r = 1'b1;
					end else if (pos < lo + stride) begin
						pos = lo;
						new_r = 1'b1;
					end else begin
						pos -= stride;
						new_r = 1'b0;
					end
				end
				chan_pos[r.chan]   = pos[POS_W-1:0];
				flag_left[r.chan]  = new_l;
				flag_right[r.chan] = new_r;
				want.chan              = r.chan;
				want.res.position      = pos[POS_W-1:0];
				want.res.at_left       = new_l;
				want.res.at_right      = new_r;
				want.res.left_changed  = new_l != old_l;
				want.res.right_changed = new_r != old_r;
				want.res.left_request  = servo_cfg.command_sense_enable
					&& !cmd_left[r.chan] && r.btn_left;
				want.res.right_request = servo_cfg.command_sense_enable
					&& !cmd_right[r.chan] && r.btn_right;
				expected_ticks.push_back(want);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	function automatic void check_result(input logic [M_DATA_W-1:0] word);
		servo_result_t want;
		if (expected_ticks.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %h arrived with nothing expected", word);
			return;
		end
		want = expected_ticks.pop_front();
		compare_field("out_channel", want.chan, word[2:0]);
		compare_field("position", want.res.position, word[18:3]);
		compare_field("at_left", want.res.at_left, word[19]);
		compare_field("at_right", want.res.at_right, word[20]);
		compare_field("left_flag_changed", want.res.left_changed, word[21]);
		compare_field("right_flag_changed", want.res.right_changed, word[22]);
		compare_field("left_request", want.res.left_request, word[23]);
		compare_field("right_request", want.res.right_request, word[24]);
		compare_field("upper padding", 0, word[M_DATA_W-1:25]);
	endfunction

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_request(tx_item);
				accepted_cnt++;
			end
			if (s_tvalid && !s_tready) begin
				// transaction still pending, keep it on the bus
			end else if (tx_gap > 0) begin
				s_tvalid <= 1'b0;
				tx_gap--;
			end else if (pending_reqs.size() > 0) begin
				tx_item = pending_reqs.pop_front();
				s_tdata  <= {tx_item.btn_right, tx_item.btn_left, tx_item.end_right,
					tx_item.end_left, tx_item.value, tx_item.chan};
				s_tuser  <= tx_item.req;
				s_tvalid <= 1'b1;
				tx_gap = quiet_tx ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) check_result(m_tdata);
			if (long_hold) rx_hold = LONG_HOLD;
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else if (!quiet_rx && chance(30)) begin
				rx_hold = pick_gap();
				if (rx_hold > 0) begin
					m_tready <= 1'b0;
					rx_hold--;
				end else begin
					m_tready <= 1'b1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("multi_channel_servo_slew_positioner_core verification failed");
			$finish;
		end
	end

	task automatic queue_req(input logic [REQ_W-1:0] req, input int ch, input logic val,
		input logic el, input logic er, input logic bl, input logic br);
		servo_req_t r;
		r.req       = req;
		r.chan      = ch[CHAN_W-1:0];
		r.value     = val;
		r.end_left  = el;
		r.end_right = er;
		r.btn_left  = bl;
		r.btn_right = br;
		pending_reqs.push_back(r);
		queued_cnt++;
	endtask

	// episodes: set a channel's commands, then tick it repeatedly, with some noise
	task automatic queue_random(input int count);
		int sent;
		int ch;
		int mode;
		int n_ticks;
		int k;
		logic [REQ_W-1:0] req;
		sent = 0;
		@(negedge clk);
		while (sent < count) begin
			ch   = $urandom_range(0, N_CHAN - 1);
			mode = $urandom_range(0, 3);
			queue_req(REQ_SET_LEFT, ch, mode[0], chance(50), chance(50), chance(50),
				chance(50));
			queue_req(REQ_SET_RIGHT, ch, mode[1], chance(50), chance(50), chance(50),
				chance(50));
			sent += 2;
			n_ticks = $urandom_range(1, 40);
			for (k = 0; k < n_ticks; k++) begin
				if (chance(10)) begin
					req = 2'($urandom_range(0, 3));
					queue_req(req, $urandom_range(0, N_CHAN - 1), chance(50), chance(50),
						chance(50), chance(50), chance(50));
					if (req != REQ_UNUSED) sent++;
				end else begin
					queue_req(REQ_TICK, ch, chance(50), chance(8), chance(8), chance(30),
						chance(30));
					sent++;
				end
			end
		end
	endtask

	// waits until every queued transaction is accepted and every result is back
	task automatic wait_drained();
		do @(negedge clk);
		while (accepted_cnt != queued_cnt || expected_ticks.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_RANGE_LO:  servo_cfg.range_lo = val;
			CFG_RANGE_HI:  servo_cfg.range_hi = val;
			CFG_STEP_SIZE: servo_cfg.step_size = val;
			CFG_END_SENSE: servo_cfg.end_sense_enable = val[0];
			CFG_CMD_SENSE: servo_cfg.command_sense_enable = val[0];
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
		input logic [POS_W-1:0] stride, input logic end_sense, input logic cmd_sense);
		write_reg(CFG_RANGE_LO, lo);
		write_reg(CFG_RANGE_HI, hi);
		write_reg(CFG_STEP_SIZE, stride);
		write_reg(CFG_END_SENSE, {15'd0, end_sense});
		write_reg(CFG_CMD_SENSE, {15'd0, cmd_sense});
	endtask

	initial begin
		servo_cfg.range_lo             = RANGE_LO_RST;
		servo_cfg.range_hi             = RANGE_HI_RST;
		servo_cfg.step_size            = STEP_SIZE_RST;
		servo_cfg.end_sense_enable     = 1'b1;
		servo_cfg.command_sense_enable = 1'b1;
		for (int i = 0; i < N_CHAN; i++) begin
			cmd_left[i]   = 1'b0;
			cmd_right[i]  = 1'b0;
			flag_left[i]  = 1'b0;
			flag_right[i] = 1'b0;
			chan_pos[i]   = POS_RST;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under reset settings
		@(negedge clk);
		queue_req(REQ_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 7, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
		queue_req(REQ_SET_LEFT, 0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
		queue_req(REQ_TICK, 0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_SET_RIGHT, 0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_req(REQ_SET_LEFT, 0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_req(REQ_TICK, 0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
		queue_req(REQ_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
		// unused request type is dropped without a result
		queue_req(REQ_UNUSED, 5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_req(REQ_SET_RIGHT, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_SET_LEFT, 3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 3, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		queue_req(REQ_SET_RIGHT, 4, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 4, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
		queue_req(REQ_SET_LEFT, 6, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_SET_RIGHT, 6, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
		queue_req(REQ_TICK, 6, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
		queue_random(250);
		wait_drained();

		// widest range, largest step, both sense inputs off
		set_config(16'd0, 16'hffff, 16'hffff, 1'b0, 1'b0);
		queue_random(200);
		wait_drained();

		// inverted range and zero step
		set_config(16'hffff, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_random(150);
		wait_drained();

		// sender streams while the receiver holds off to back up the block
		set_config(16'd100, 16'd400, 16'd7, 1'b1, 1'b1);
		quiet_tx <= 1'b1;
		queue_random(250);
		@(posedge clk);
		long_hold <= 1'b1;
		@(posedge clk);
		long_hold <= 1'b0;
		wait_drained();
		quiet_tx <= 1'b0;

		// narrow range at unit step, no idling on either side
		set_config(16'd0, 16'd20, 16'd1, 1'b1, 1'b0);
		quiet_tx <= 1'b1;
		quiet_rx <= 1'b1;
		queue_random(200);
		wait_drained();
		quiet_tx <= 1'b0;
		quiet_rx <= 1'b0;

		repeat (3) begin
			set_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
				chance(10) ? 16'd0 : 16'($urandom_range(1, 300)), chance(50), chance(50));
			write_reg(CFG_UNUSED_IDX, 16'($urandom_range(0, 65535)));
			queue_random(150);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		mismatches += expected_ticks.size();
		if (mismatches == 0) begin
			$display("multi_channel_servo_slew_positioner_core verification clean");
		end else begin
			$display("multi_channel_servo_slew_positioner_core verification failed");
		end
		$finish;
	end

endmodule
